// ----- sv/skf_pkg.sv -----
// Shared types and constants of the scalar Kalman filter.
`default_nettype none

package skf_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_OFFSET   = 2'd2;

  // Reset value of the measurement noise register (1.0 in Q16.16).
  localparam int unsigned MEASURE_NOISE_RST = 65536;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // Input beat taken: apply restart, form P + q and z - x.
    logic setup;     // Form the divisor and clear the accumulators.
    logic div_step;  // One quotient bit of the gain.
    logic div_first; // First quotient bit: remainder is not doubled.
    logic acc_last;  // Fold the last quotient bit into the products.
    logic finish;    // Form the new estimate and variance.
  } skf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // The output register can take a result this cycle.
  } skf_stat_t;

endpackage

`default_nettype wire

// ----- sv/skf_if.sv -----
// Handshake channel interfaces of the scalar Kalman filter.
`default_nettype none

interface skf_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample;
  logic                         restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink (input valid, input sample, input restart, output ready);
endinterface

interface skf_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] estimate;
  logic [DATA_WIDTH-1:0]        error_variance;

  modport source (output valid, output estimate, output error_variance, input ready);
  modport sink (input valid, input estimate, input error_variance, output ready);
endinterface

interface skf_cfg_if #(
  parameter int DATA_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic [skf_pkg::CFG_IDX_W-1:0]  index;
  logic [DATA_WIDTH-1:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/scalar_kalman_filter.sv -----
// Top level of the scalar Kalman filter: controller and datapath.
`default_nettype none

// One-dimensional Kalman filter on a stream of signed fixed-point samples
// with DATA_WIDTH bits and FRAC_BITS fraction bits (Q16.16 by default).
// For each input beat the filter adds the process noise to the variance,
// computes the gain K = P / (P + r), updates the estimate as
// x + K * (z - x) - offset, shrinks the variance to (1 - K) * P and returns
// the new estimate and variance as one output beat. When the restart bit is
// set, the estimate and variance are cleared before the sample is used. A
// zero denominator gives a zero gain, and the estimate saturates at the
// signed range of the format while the variance sum saturates at its
// unsigned maximum. After the accepting edge the sample passes through the
// setup, divide, accumulate and finish states before its result is loaded
// into the output register, and the next sample is accepted in the cycle
// after that. The divide state runs a restoring divider, which produces one
// gain bit per cycle; the two products with the gain are accumulated bit
// by bit alongside, plus a last step for the final bit. The output register
// holds a finished result until it is taken, and the next sample may be
// accepted and worked on meanwhile; its result then waits until the output
// register is free. Configuration registers are written through their own
// channel, which is always ready, and must only be written while the filter
// is idle. A write to an index beyond the bias offset register is ignored.
module scalar_kalman_filter #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  skf_in_if.sink    in_i,
  skf_out_if.source out_o,
  skf_cfg_if.sink   cfg_i
);
  import skf_pkg::*;

  // Commands flow from the controller, status back from the datapath.
  skf_cmd_t  cmd;
  skf_stat_t stat;

  skf_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  skf_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .sample_i         (in_i.sample),
    .restart_i        (in_i.restart),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_ready_o      (cfg_i.ready),
    .cfg_index_i      (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .estimate_o       (out_o.estimate),
    .error_variance_o (out_o.error_variance)
  );

endmodule

`default_nettype wire

// ----- sv/skf_ctrl.sv -----
// Sequencing state machine of the scalar Kalman filter.
`default_nettype none

module skf_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire skf_pkg::skf_stat_t stat_i,
  output skf_pkg::skf_cmd_t       cmd_o
);
  import skf_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_ACC,
    ST_FIN
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(FRAC_BITS)) begin
          state_d = ST_ACC;
          cnt_d   = '0;
        end
      end
      ST_ACC: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign cmd_o.load      = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.setup     = (state_q == ST_SETUP);
  assign cmd_o.div_step  = (state_q == ST_DIV);
  assign cmd_o.div_first = (state_q == ST_DIV) && (cnt_q == '0);
  assign cmd_o.acc_last  = (state_q == ST_ACC);
  assign cmd_o.finish    = (state_q == ST_FIN) && stat_i.out_free;

`ifndef ASSERT_OFF
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_DIV) |-> (cnt_q == '0))
    else $error("Step counter is not cleared outside the divide phase.");

  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && !stat_i.out_free) |=> (state_q == ST_FIN))
    else $error("Result left before the output register was free.");
`endif

endmodule

`default_nettype wire

// ----- sv/skf_datapath.sv -----
// Arithmetic, state and configuration registers of the scalar Kalman filter.
`default_nettype none

module skf_datapath #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire skf_pkg::skf_cmd_t               cmd_i,
  output skf_pkg::skf_stat_t                   stat_o,
  input  wire logic signed [DATA_WIDTH-1:0]    sample_i,
  input  wire logic                            restart_i,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [skf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [DATA_WIDTH-1:0]           cfg_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [DATA_WIDTH-1:0]         estimate_o,
  output logic [DATA_WIDTH-1:0]                error_variance_o
);
  import skf_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int AXW = W + F + 2;  // k * (z - x), signed
  localparam int APW = W + F + 1;  // k * P', unsigned

  localparam logic signed [W-1:0] SMAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN_W = {1'b1, {(W-1){1'b0}}};

  // Configuration registers.
  logic [W-1:0]          q_q;
  logic [W-1:0]          r_q;
  logic signed [W-1:0]   bias_q;

  // Filter state.
  logic signed [W-1:0]   x_q;
  logic [W-1:0]          var_q;

  // Per-sample working registers.
  logic [W-1:0]          p_q;
  logic signed [W:0]     diff_q;
  logic [W:0]            den_q;
  logic                  den_zero_q;
  logic [W:0]            rem_q;
  logic                  qbit_q;
  logic signed [AXW-1:0] acc_x_q;
  logic [APW-1:0]        acc_p_q;

  // Output register.
  logic                  out_valid_q;
  logic signed [W-1:0]   est_q;
  logic [W-1:0]          evar_q;

  // Load-time terms.
  logic signed [W-1:0]   x_eff;
  logic [W-1:0]          v_eff;
  logic [W:0]            psum;
  logic [W-1:0]          p_d;
  logic signed [W:0]     diff_d;

  // Divider step.
  logic [W+1:0]          trial;
  logic                  ge;
  logic [W+1:0]          trial_sub;

  // Accumulator step.
  logic signed [AXW-1:0] addend_x;
  logic [APW-1:0]        addend_p;

  // Final terms.
  logic signed [AXW-1:0] sum_x;
  logic signed [W-1:0]   x_new;
  logic [APW-1:0]        var_full;

  assign x_eff  = restart_i ? '0 : x_q;
  assign v_eff  = restart_i ? '0 : var_q;
  assign psum   = {1'b0, v_eff} + {1'b0, q_q};
  assign p_d    = psum[W] ? {W{1'b1}} : psum[W-1:0];
  assign diff_d = (W+1)'(sample_i) - (W+1)'(x_eff);

  assign trial     = cmd_i.div_first ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign ge        = !den_zero_q && (trial >= {1'b0, den_q});
  assign trial_sub = trial - {1'b0, den_q};

  assign addend_x = qbit_q ? AXW'(diff_q) : '0;
  assign addend_p = qbit_q ? APW'(p_q) : '0;

  assign sum_x = AXW'(x_q) + (acc_x_q >>> F) - AXW'(bias_q);
  always_comb begin
    if (sum_x > AXW'(SMAX_W)) begin
      x_new = SMAX_W;
    end else if (sum_x < AXW'(SMIN_W)) begin
      x_new = SMIN_W;
    end else begin
      x_new = sum_x[W-1:0];
    end
  end
  assign var_full = {1'b0, p_q, {F{1'b0}}} - acc_p_q;

  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // Configuration writes.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q    <= '0;
      r_q    <= W'(MEASURE_NOISE_RST);
      bias_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PROCESS_NOISE: q_q    <= cfg_data_i;
        REG_MEASURE_NOISE: r_q    <= cfg_data_i;
        REG_BIAS_OFFSET:   bias_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Filter state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q         <= '0;
      var_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        x_q <= x_eff;
      end else if (cmd_i.finish) begin
        x_q   <= x_new;
        var_q <= var_full[W+F-1:F];
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers and output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p_q    <= p_d;
      diff_q <= diff_d;
    end
    if (cmd_i.setup) begin
      den_q      <= {1'b0, p_q} + {1'b0, r_q};
      den_zero_q <= (p_q == '0) && (r_q == '0);
      rem_q      <= {1'b0, p_q};
      qbit_q     <= 1'b0;
      acc_x_q    <= '0;
      acc_p_q    <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= ge ? trial_sub[W:0] : trial[W:0];
      qbit_q <= ge;
    end
    if (cmd_i.div_step || cmd_i.acc_last) begin
      acc_x_q <= (acc_x_q <<< 1) + addend_x;
      acc_p_q <= (acc_p_q << 1) + addend_p;
    end
    if (cmd_i.finish) begin
      est_q  <= x_new;
      evar_q <= var_full[W+F-1:F];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign estimate_o       = est_q;
  assign error_variance_o = evar_q;

`ifndef ASSERT_OFF
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_step && !cmd_i.div_first && !den_zero_q) |-> (rem_q < den_q))
    else $error("Divider remainder is not below the divisor.");

  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.finish))
    else $error("Output valid rose without a finished sample.");

  a_var_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (var_q <= $past(p_q)))
    else $error("Updated variance exceeds the predicted variance.");
`endif

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the scalar Kalman filter: directed cases, then random phases.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import skf_pkg::*;

  // The filter runs in its default Q16.16 configuration.
  localparam int DW = 32;
  localparam int FB = 16;

  // A register index past the last register. Writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Bounds of the fixed-point formats, kept in 64-bit arithmetic.
  localparam longint ONE     = longint'(1) << FB;
  localparam longint VAR_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam longint EST_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint EST_MIN = -64'sh0000_0000_8000_0000;

  // After the last result has arrived, the bench waits out the SETTLE pause
  // before the filter counts as idle, and before the run is judged at the end.
  localparam int SETTLE = FB + 15;

  // In the slowest case a sample waits through sender gaps, the filter's work
  // and an output stall. The limit is several times what about two thousand
  // samples need.
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int RANDOM_ITEMS = 1950;
  localparam int PHASES       = 13;

  typedef struct {
    logic signed [DW-1:0] estimate;
    logic [DW-1:0]        variance;
  } kf_result_t;

  logic clk_i;
  logic rst_ni;

  skf_in_if  #(.DATA_WIDTH(DW)) in_if ();
  skf_out_if #(.DATA_WIDTH(DW)) out_if ();
  skf_cfg_if #(.DATA_WIDTH(DW)) cfg_if ();

  scalar_kalman_filter #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Predicted filter state and register contents, mirrored from the beats
  // that the filter accepts.
  logic signed [DW-1:0] est_state = '0;
  logic [DW-1:0]        var_state = '0;
  logic [DW-1:0]        q_reg     = '0;
  logic [DW-1:0]        r_reg     = DW'(MEASURE_NOISE_RST);
  logic signed [DW-1:0] off_reg   = '0;

  // Results predicted for accepted samples, oldest first.
  kf_result_t pending_results[$];

  int  mismatches  = 0;
  int  cycle_count = 0;
  int  hold_cycles = 0;
  int  trend       = 0;
  // When set, neither side of the data path idles.
  bit  calm        = 1'b0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Every mismatch is counted. Printing stops after the first few dozen so
  // that a broken build does not flood the log.
  task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                 input logic [DW-1:0] want);
    if (mismatches < 40) begin
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    end
    mismatches++;
  endtask

  // One filter step: the prior variance picks up the process noise and
  // saturates, the gain is the truncated quotient P / (P + r) with a zero
  // denominator giving a zero gain, the correction K * (z - x) is floored
  // to whole units of the format, the offset is taken off and the estimate
  // is clamped to the signed range. The posterior variance is (1 - K) * P,
  // truncated.
  function automatic kf_result_t filter_update(input logic signed [DW-1:0] z,
                                               input logic restart);
    longint p_prior;
    longint den;
    longint gain;
    longint diff;
    longint step;
    longint x_new;
    longint p_post;
    kf_result_t res;
    if (restart) begin
      est_state = '0;
      var_state = '0;
    end
    p_prior = longint'(var_state) + longint'(q_reg);
    if (p_prior > VAR_MAX) begin
      p_prior = VAR_MAX;
    end
    den  = p_prior + longint'(r_reg);
    gain = (den == 0) ? 0 : (p_prior * ONE) / den;
    diff = longint'(z) - longint'(est_state);
    // An arithmetic shift of a signed value rounds toward minus infinity.
    step  = (gain * diff) >>> FB;
    x_new = longint'(est_state) + step - longint'(off_reg);
    if (x_new > EST_MAX) begin
      x_new = EST_MAX;
    end else if (x_new < EST_MIN) begin
      x_new = EST_MIN;
    end
    p_post = ((ONE - gain) * p_prior) >>> FB;
    est_state    = x_new[DW-1:0];
    var_state    = p_post[DW-1:0];
    res.estimate = est_state;
    res.variance = var_state;
    return res;
  endfunction

  // The result side stalls in random bursts, except while calm is set.
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles  <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      hold_cycles  <= $urandom_range(0, 2);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Each result beat is compared field by field with the oldest prediction.
  // Signals are read right at the clock edge, before any nonblocking update
  // of that edge, so they hold the values the filter saw.
  always @(posedge clk_i) begin
    kf_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with no sample outstanding", out_if.estimate, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_if.estimate !== want.estimate) begin
          report_mismatch("estimate", out_if.estimate, want.estimate);
        end
        if (out_if.error_variance !== want.variance) begin
          report_mismatch("error variance", out_if.error_variance, want.variance);
        end
      end
    end
  end

  // A run that hangs ends here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL scalar_kalman_filter");
    $finish;
  end

  // The tasks below are entered right after a rising edge and drive the
  // filter's inputs with nonblocking assignments only.

  // Sends one sample beat, sometimes after a pause made of a few idle
  // bursts, and records its predicted result once the beat is taken.
  task automatic send_sample(input logic signed [DW-1:0] z, input logic restart);
    kf_result_t predicted;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) begin
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
    end
    in_if.valid   <= 1'b1;
    in_if.sample  <= z;
    in_if.restart <= restart;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predicted = filter_update(z, restart);
    pending_results = {pending_results, predicted};
  endtask

  // Writes one register. The mirror follows the write, and an index past
  // the last register leaves everything as it was.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      REG_PROCESS_NOISE: q_reg = value;
      REG_MEASURE_NOISE: r_reg = value;
      REG_BIAS_OFFSET:   off_reg = value;
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Holds back new samples until every outstanding result has been taken,
  // then lets the filter settle.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic configure(input logic [DW-1:0] q, input logic [DW-1:0] r,
                           input logic [DW-1:0] off);
    wait_idle();
    write_reg(REG_PROCESS_NOISE, q);
    write_reg(REG_MEASURE_NOISE, r);
    write_reg(REG_BIAS_OFFSET, off);
  endtask

  // With the reset registers the variance stays zero, so the gain is zero
  // and the estimate must hold at its reset value whatever comes in.
  task automatic test_reset_state();
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh8000_0000, 1'b1);
    send_sample(32'sh0000_0000, 1'b0);
  endtask

  // Unit noise on both sides and the extremes of the sample range.
  task automatic test_sample_extremes();
    configure(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
    send_sample(32'sh7FFF_FFFF, 1'b1);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b1);
    send_sample(32'sh0001_0000, 1'b0);
    send_sample(32'shFFFF_FFFF, 1'b0);
  endtask

  // No noise at all makes the gain denominator zero, so the gain must be
  // zero. A process noise of one least significant bit then gives a gain of exactly one.
  task automatic test_zero_denominator();
    configure(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_sample(32'sh0005_0000, 1'b1);
    send_sample(32'shFFFB_0000, 1'b0);
    configure(32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
    send_sample(32'sh1234_5678, 1'b0);
  endtask

  // Maximum process noise pushes the prior variance past the top of its
  // range from the second sample on.
  task automatic test_variance_saturation();
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_sample($urandom(), 1'b1);
    send_sample($urandom(), 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
  endtask

  // A gain of one makes the estimate the sample minus the offset. The most
  // negative offset drives it past the top of the range, the most positive
  // one past the bottom.
  task automatic test_estimate_saturation();
    configure(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000);
    send_sample(32'sh7FFF_FFFF, 1'b1);
    send_sample(32'sh0000_0001, 1'b0);
    configure(32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'shFFFF_FFFF, 1'b0);
  endtask

  // A write past the last register must be dropped.
  task automatic test_unused_index();
    configure(32'h0000_4000, 32'h0002_0000, 32'h0000_0100);
    write_reg(REG_UNUSED, $urandom());
    send_sample(32'sh0003_0000, 1'b1);
    send_sample(32'sh0003_8000, 1'b0);
  endtask

  function automatic logic [DW-1:0] pick_noise();
    case ($urandom_range(0, 6))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom_range(0, 32'h0002_0000);
      4:       return $urandom_range(0, 32'h0000_1000);
      5:       return $urandom_range(0, 32'h0100_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_offset();
    case ($urandom_range(0, 7))
      0, 1:    return 32'h0000_0000;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4, 5, 6: return $urandom_range(0, 32'h0000_2000) - 32'h0000_1000;
      default: return $urandom();
    endcase
  endfunction

  // Most samples follow a slowly drifting level with noise on top, the way
  // a sensor reading would, so the filter settles and tracks. The rest are
  // arbitrary words, extremes and small values near zero.
  function automatic logic signed [DW-1:0] pick_sample();
    trend += int'($urandom_range(0, 32'h800)) - 32'sh400;
    case ($urandom_range(0, 9))
      6:       return $urandom();
      7:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      8:       return int'($urandom_range(0, 32'h200)) - 32'sh100;
      default: return trend + int'($urandom_range(0, 32'h0001_0000)) - 32'sh8000;
    endcase
  endfunction

  // Random phases, each with its own register setting. The filter is
  // drained before each setting is written. Some phases run without any
  // idling, and so does the last one.
  task automatic test_random_phases();
    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph == PHASES - 1) || ($urandom_range(0, 3) == 0);
      configure(pick_noise(), pick_noise(), pick_offset());
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        send_sample(pick_sample(), $urandom_range(0, 31) == 0);
      end
    end
  endtask

  initial begin
    kf_result_t left;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.sample  = '0;
    in_if.restart = 1'b0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = REG_PROCESS_NOISE;
    cfg_if.data   = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_sample_extremes();
    test_zero_denominator();
    test_variance_saturation();
    test_estimate_saturation();
    test_unused_index();
    test_random_phases();

    wait_idle();
    while (pending_results.size() != 0) begin
      left = pending_results.pop_front();
      report_mismatch("result never arrived", '0, left.estimate);
    end
    if (mismatches == 0) begin
      $display("PASS scalar_kalman_filter");
    end else begin
      $display("FAIL scalar_kalman_filter");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/skf_pkg.sv
sv/skf_if.sv
sv/skf_ctrl.sv
sv/skf_datapath.sv
sv/scalar_kalman_filter.sv
test/testbench.sv
